@@ src/rmwq_pkg.sv @@
// Shared codes, types and default parameter values of the recursive mutex block.
package rmwq_pkg;

	localparam int DEF_MAX_WAITERS    = 16;
	localparam int DEF_NUM_REQUESTERS = 32;
	localparam int DEF_MAX_DEPTH      = 255;

	localparam int OP_W     = 2;
	localparam int ID_W     = 5;
	localparam int STATUS_W = 3;
	localparam int DEPTH_W  = 8;

	typedef enum logic [OP_W-1:0] {
		OP_LOCK   = 2'd0,
		OP_TRY    = 2'd1,
		OP_UNLOCK = 2'd2,
		OP_CANCEL = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACQUIRED   = 3'd0,
		ST_QUEUED     = 3'd1,
		ST_BUSY       = 3'd2,
		ST_STILL_HELD = 3'd3,
		ST_FREED      = 3'd4,
		ST_CANCELLED  = 3'd5,
		ST_REJECTED   = 3'd6,
		ST_OVERFLOW   = 3'd7
	} status_t;

endpackage

@@ src/rmwq_waitq.sv @@
// Wait queue storage: one write port and one registered read port.
module rmwq_waitq #(
	parameter int DEPTH = rmwq_pkg::DEF_MAX_WAITERS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [rmwq_pkg::ID_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [rmwq_pkg::ID_W-1:0] rdata
);

	logic [rmwq_pkg::ID_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/recursive_mutex_with_wait_queue_core.sv @@
// Top level of the recursive mutex: request sequencer, lock state and result register.
//
//  channel | direction | handshake          | fields
//  in      | in        | in_valid, in_stall | op, requester
//  out     | out       | out_valid, out_stall | status, wake_valid, wake_id, hold_depth
//
// Lock, try and unlock without a queue pop or search go from the idle state straight to the done state.
// A queue search reads and then compares each entry visited, through the single queue read port.
// Removing a waiter reads and writes each entry moved down; a pop first reads and captures the head.
// Reset clears the lock and empties the queue.
// A finished word waits in the output register; a new word is taken meanwhile.
module recursive_mutex_with_wait_queue_core #(
	parameter int MAX_WAITERS    = rmwq_pkg::DEF_MAX_WAITERS,
	parameter int NUM_REQUESTERS = rmwq_pkg::DEF_NUM_REQUESTERS,
	parameter int MAX_DEPTH      = rmwq_pkg::DEF_MAX_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rmwq_pkg::OP_W-1:0]     op,
	input  logic [rmwq_pkg::ID_W-1:0]     requester,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rmwq_pkg::STATUS_W-1:0] status,
	output logic                          wake_valid,
	output logic [rmwq_pkg::ID_W-1:0]     wake_id,
	output logic [rmwq_pkg::DEPTH_W-1:0]  hold_depth
);

	localparam int AW   = $clog2(MAX_WAITERS);
	localparam int CW   = $clog2(MAX_WAITERS + 1);
	localparam int DLIM = (MAX_DEPTH < 255) ? MAX_DEPTH : 255;
	localparam logic [8:0]                         NREQ      = 9'(NUM_REQUESTERS);
	localparam logic [CW-1:0]                      QMAX      = CW'(MAX_WAITERS);
	localparam logic [rmwq_pkg::DEPTH_W-1:0]       DEPTH_LIM = rmwq_pkg::DEPTH_W'(DLIM);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_SCAN_RD  = 8'b0000_0010,
		S_SCAN_CMP = 8'b0000_0100,
		S_SH_RD    = 8'b0000_1000,
		S_SH_WR    = 8'b0001_0000,
		S_POP_RD   = 8'b0010_0000,
		S_POP_CAP  = 8'b0100_0000,
		S_DONE     = 8'b1000_0000
	} state_t;

	state_t                          state_q;
	logic                            held_q;
	logic [rmwq_pkg::ID_W-1:0]       owner_q;
	logic [rmwq_pkg::DEPTH_W-1:0]    depth_q;
	logic [CW-1:0]                   count_q;
	logic [CW-1:0]                   idx_q;
	rmwq_pkg::op_t                   op_q;
	logic [rmwq_pkg::ID_W-1:0]       id_q;
	rmwq_pkg::status_t               res_status_q;
	logic                            res_wake_q;
	logic [rmwq_pkg::ID_W-1:0]       res_wake_id_q;

	logic                            out_valid_q;
	logic [rmwq_pkg::STATUS_W-1:0]   status_q;
	logic                            wake_valid_q;
	logic [rmwq_pkg::ID_W-1:0]       wake_id_q;
	logic [rmwq_pkg::DEPTH_W-1:0]    hold_depth_q;

	logic                            accept;
	logic                            in_range;
	logic                            done_fire;
	logic [CW-1:0]                   idx_next;
	logic                            scan_end;
	logic                            id_match;
	logic                            mem_we;
	logic [AW-1:0]                   mem_waddr;
	logic [rmwq_pkg::ID_W-1:0]       mem_wdata;
	logic [AW-1:0]                   mem_raddr;
	logic [rmwq_pkg::ID_W-1:0]       mem_rdata;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign in_range  = ({4'b0, requester} < NREQ);
	assign done_fire = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign idx_next  = idx_q + CW'(1);
	assign scan_end  = (idx_q >= count_q);
	assign id_match  = (mem_rdata == id_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = mem_rdata;
		case (state_q)
			S_SCAN_RD: begin
				mem_raddr = idx_q[AW-1:0];
				if (scan_end && op_q == rmwq_pkg::OP_LOCK && count_q < QMAX) begin
					mem_we    = 1'b1;
					mem_waddr = count_q[AW-1:0];
					mem_wdata = id_q;
				end
			end
			S_SH_RD:  mem_raddr = idx_next[AW-1:0];
			S_SH_WR: begin
				mem_raddr = idx_q[AW-1:0];
				mem_we    = 1'b1;
			end
			S_POP_RD: mem_raddr = '0;
			default:  mem_raddr = idx_q[AW-1:0];
		endcase
	end

	rmwq_waitq #(
		.DEPTH (MAX_WAITERS),
		.AW    (AW)
	) u_waitq (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			held_q  <= 1'b0;
			owner_q <= '0;
			depth_q <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						state_q <= S_DONE;
						if (!in_range) begin
							state_q <= S_DONE;
						end else if (op == rmwq_pkg::OP_LOCK || op == rmwq_pkg::OP_TRY) begin
							if (!held_q) begin
								held_q  <= 1'b1;
								owner_q <= requester;
								depth_q <= rmwq_pkg::DEPTH_W'(1);
							end else if (owner_q == requester) begin
								if (depth_q < DEPTH_LIM) begin
									depth_q <= depth_q + rmwq_pkg::DEPTH_W'(1);
								end
							end else if (op == rmwq_pkg::OP_LOCK) begin
								state_q <= S_SCAN_RD;
							end
						end else if (op == rmwq_pkg::OP_UNLOCK) begin
							if (held_q && owner_q == requester) begin
								if (depth_q > rmwq_pkg::DEPTH_W'(1)) begin
									depth_q <= depth_q - rmwq_pkg::DEPTH_W'(1);
								end else begin
									depth_q <= '0;
									held_q  <= 1'b0;
									owner_q <= '0;
									if (count_q != '0) begin
										state_q <= S_POP_RD;
									end
								end
							end
						end else begin
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: begin
					if (scan_end) begin
						if (op_q == rmwq_pkg::OP_LOCK && count_q < QMAX) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN_CMP;
					end
				end
				S_SCAN_CMP: begin
					if (id_match) begin
						state_q <= (op_q == rmwq_pkg::OP_CANCEL) ? S_SH_RD : S_DONE;
					end else begin
						idx_q   <= idx_next;
						state_q <= S_SCAN_RD;
					end
				end
				S_SH_RD: begin
					if (idx_next < count_q) begin
						state_q <= S_SH_WR;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_SH_WR: begin
					idx_q   <= idx_next;
					state_q <= S_SH_RD;
				end
				S_POP_RD:  state_q <= S_POP_CAP;
				S_POP_CAP: begin
					idx_q   <= '0;
					state_q <= S_SH_RD;
				end
				S_DONE: begin
					if (done_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q          <= rmwq_pkg::op_t'(op);
					id_q          <= requester;
					res_wake_q    <= 1'b0;
					res_wake_id_q <= '0;
					res_status_q  <= rmwq_pkg::ST_REJECTED;
					if (in_range) begin
						case (rmwq_pkg::op_t'(op))
							rmwq_pkg::OP_LOCK, rmwq_pkg::OP_TRY: begin
								if (!held_q) begin
									res_status_q <= rmwq_pkg::ST_ACQUIRED;
								end else if (owner_q == requester) begin
									res_status_q <= (depth_q < DEPTH_LIM) ?
										rmwq_pkg::ST_ACQUIRED : rmwq_pkg::ST_OVERFLOW;
								end else begin
									res_status_q <= rmwq_pkg::ST_BUSY;
								end
							end
							rmwq_pkg::OP_UNLOCK: begin
								if (held_q && owner_q == requester) begin
									res_status_q <= (depth_q > rmwq_pkg::DEPTH_W'(1)) ?
										rmwq_pkg::ST_STILL_HELD : rmwq_pkg::ST_FREED;
								end
							end
							default: res_status_q <= rmwq_pkg::ST_REJECTED;
						endcase
					end
				end
			end
			S_SCAN_RD: begin
				if (scan_end) begin
					if (op_q == rmwq_pkg::OP_LOCK) begin
						res_status_q <= (count_q < QMAX) ?
							rmwq_pkg::ST_QUEUED : rmwq_pkg::ST_OVERFLOW;
					end else begin
						res_status_q <= rmwq_pkg::ST_REJECTED;
					end
				end
			end
			S_SCAN_CMP: begin
				if (id_match) begin
					res_status_q <= (op_q == rmwq_pkg::OP_CANCEL) ?
						rmwq_pkg::ST_CANCELLED : rmwq_pkg::ST_QUEUED;
				end
			end
			S_POP_CAP: begin
				res_wake_q    <= 1'b1;
				res_wake_id_q <= mem_rdata;
			end
			default: begin
				res_wake_q <= res_wake_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			status_q     <= res_status_q;
			wake_valid_q <= res_wake_q;
			wake_id_q    <= res_wake_id_q;
			hold_depth_q <= depth_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign wake_valid = wake_valid_q;
	assign wake_id    = wake_id_q;
	assign hold_depth = hold_depth_q;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the recursive mutex with its queue of waiting requesters.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_WAIT     = rmwq_pkg::DEF_MAX_WAITERS;
	localparam int N_REQ      = rmwq_pkg::DEF_NUM_REQUESTERS;
	localparam int DEPTH_LIM  = (rmwq_pkg::DEF_MAX_DEPTH < 255) ? rmwq_pkg::DEF_MAX_DEPTH : 255;
	localparam int LAT_CYCLES = 4 * N_WAIT + 40;

	typedef struct packed {
		rmwq_pkg::status_t                 status;
		logic                              wake_valid;
		logic [rmwq_pkg::ID_W-1:0]         wake_id;
		logic [rmwq_pkg::DEPTH_W-1:0]      hold_depth;
	} lock_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [rmwq_pkg::OP_W-1:0]     op = '0;
	logic [rmwq_pkg::ID_W-1:0]     requester = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [rmwq_pkg::STATUS_W-1:0] status;
	logic                          wake_valid;
	logic [rmwq_pkg::ID_W-1:0]     wake_id;
	logic [rmwq_pkg::DEPTH_W-1:0]  hold_depth;

	// Lock state as the testbench expects it to be.
	logic                         lk_held = 1'b0;
	logic [rmwq_pkg::ID_W-1:0]    lk_owner = '0;
	logic [rmwq_pkg::DEPTH_W-1:0] lk_depth = '0;
	logic [rmwq_pkg::ID_W-1:0]    wait_q[$];

	lock_result_t result_q[$];
	lock_result_t last_pred;
	int           err_count = 0;
	int           gap_pct = 0;
	int           hold_cycles = 0;
	bit           quiet = 1'b0;

	recursive_mutex_with_wait_queue_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.requester  (requester),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.wake_valid (wake_valid),
		.wake_id    (wake_id),
		.hold_depth (hold_depth)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic lock_result_t apply_request(input rmwq_pkg::op_t o,
			input logic [rmwq_pkg::ID_W-1:0] id);
		lock_result_t r;
		int           pos;
		r.status     = rmwq_pkg::ST_REJECTED;
		r.wake_valid = 1'b0;
		r.wake_id    = '0;
		pos = -1;
		foreach (wait_q[i]) begin
			if (wait_q[i] == id && pos < 0)
				pos = i;
		end
		if (int'(id) < N_REQ) begin
			case (o)
				rmwq_pkg::OP_LOCK, rmwq_pkg::OP_TRY: begin
					if (!lk_held) begin
						lk_held  = 1'b1;
						lk_owner = id;
						lk_depth = rmwq_pkg::DEPTH_W'(1);
						r.status = rmwq_pkg::ST_ACQUIRED;
					end else if (lk_owner == id) begin
						if (int'(lk_depth) >= DEPTH_LIM) begin
							r.status = rmwq_pkg::ST_OVERFLOW;
						end else begin
							lk_depth = lk_depth + 1'b1;
							r.status = rmwq_pkg::ST_ACQUIRED;
						end
					end else if (o == rmwq_pkg::OP_TRY) begin
						r.status = rmwq_pkg::ST_BUSY;
					end else if (pos >= 0) begin
						r.status = rmwq_pkg::ST_QUEUED;
					end else if (wait_q.size() >= N_WAIT) begin
						r.status = rmwq_pkg::ST_OVERFLOW;
					end else begin
						wait_q = {wait_q, id};
						r.status = rmwq_pkg::ST_QUEUED;
					end
				end
				rmwq_pkg::OP_UNLOCK: begin
					if (!lk_held || lk_owner != id) begin
						r.status = rmwq_pkg::ST_REJECTED;
					end else if (lk_depth > 1) begin
						lk_depth = lk_depth - 1'b1;
						r.status = rmwq_pkg::ST_STILL_HELD;
					end else begin
						lk_held  = 1'b0;
						lk_owner = '0;
						lk_depth = '0;
						r.status = rmwq_pkg::ST_FREED;
						if (wait_q.size() > 0) begin
							r.wake_valid = 1'b1;
							r.wake_id    = wait_q[0];
							wait_q.delete(0);
						end
					end
				end
				default: begin
					if (pos >= 0) begin
						wait_q.delete(pos);
						r.status = rmwq_pkg::ST_CANCELLED;
					end
				end
			endcase
		end
		r.hold_depth = lk_depth;
		return r;
	endfunction

	// Valid is left high after a word is taken so that back-to-back words need no gap.
	task automatic send_word(input rmwq_pkg::op_t o, input logic [rmwq_pkg::ID_W-1:0] id);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 99) < gap_pct)
			gap = $urandom_range(1, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= o;
		requester <= id;
		do @(posedge clk); while (in_stall);
		last_pred = apply_request(o, id);
		result_q = {result_q, last_pred};
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (result_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin : rx_stall_gen
		int n;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 12);
				out_stall <= 1'b1;
				repeat (n - 1) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : result_check
		lock_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				$error("unexpected result word: status %0d", status);
				err_count++;
			end else begin
				e = result_q[0];
				result_q.delete(0);
				if (status !== e.status) begin
					$error("status: expected %0d, actual %0d", e.status, status);
					err_count++;
				end
				if (wake_valid !== e.wake_valid) begin
					$error("wake_valid: expected %0d, actual %0d", e.wake_valid, wake_valid);
					err_count++;
				end
				if (wake_id !== e.wake_id) begin
					$error("wake_id: expected %0d, actual %0d", e.wake_id, wake_id);
					err_count++;
				end
				if (hold_depth !== e.hold_depth) begin
					$error("hold_depth: expected %0d, actual %0d", e.hold_depth, hold_depth);
					err_count++;
				end
			end
		end
	end

	task automatic test_basic_ops();
		gap_pct = 20;
		send_word(rmwq_pkg::OP_UNLOCK, 5'd0);
		send_word(rmwq_pkg::OP_CANCEL, 5'd31);
		send_word(rmwq_pkg::OP_TRY, 5'd0);
		send_word(rmwq_pkg::OP_LOCK, 5'd0);
		send_word(rmwq_pkg::OP_TRY, 5'd31);
		send_word(rmwq_pkg::OP_LOCK, 5'd31);
		send_word(rmwq_pkg::OP_LOCK, 5'd31);
		send_word(rmwq_pkg::OP_UNLOCK, 5'd31);
		send_word(rmwq_pkg::OP_CANCEL, 5'd0);
		send_word(rmwq_pkg::OP_UNLOCK, 5'd0);
		send_word(rmwq_pkg::OP_UNLOCK, 5'd0);
		send_word(rmwq_pkg::OP_LOCK, 5'd31);
		send_word(rmwq_pkg::OP_LOCK, 5'd0);
		send_word(rmwq_pkg::OP_LOCK, 5'd21);
		send_word(rmwq_pkg::OP_CANCEL, 5'd0);
		send_word(rmwq_pkg::OP_UNLOCK, 5'd31);
		send_word(rmwq_pkg::OP_UNLOCK, 5'd31);
		send_word(rmwq_pkg::OP_TRY, 5'd21);
		send_word(rmwq_pkg::OP_UNLOCK, 5'd21);
		drain_results();
	endtask

	task automatic test_queue_limits();
		logic [rmwq_pkg::ID_W-1:0] w;
		gap_pct = 10;
		send_word(rmwq_pkg::OP_LOCK, 5'd1);
		for (int k = 2; k < 2 + N_WAIT; k++)
			send_word(rmwq_pkg::OP_LOCK, rmwq_pkg::ID_W'(k));
		send_word(rmwq_pkg::OP_LOCK, 5'd18);
		send_word(rmwq_pkg::OP_LOCK, 5'd2);
		send_word(rmwq_pkg::OP_TRY, 5'd18);
		send_word(rmwq_pkg::OP_CANCEL, 5'd9);
		send_word(rmwq_pkg::OP_CANCEL, 5'd17);
		send_word(rmwq_pkg::OP_CANCEL, 5'd2);
		send_word(rmwq_pkg::OP_CANCEL, 5'd2);
		for (int k = 18; k < 22; k++)
			send_word(rmwq_pkg::OP_LOCK, rmwq_pkg::ID_W'(k));
		send_word(rmwq_pkg::OP_UNLOCK, 5'd1);
		while (last_pred.wake_valid) begin
			w = last_pred.wake_id;
			send_word(rmwq_pkg::OP_LOCK, w);
			send_word(rmwq_pkg::OP_UNLOCK, w);
		end
		drain_results();
	endtask

	task automatic test_depth_saturation();
		gap_pct = 5;
		for (int k = 0; k < DEPTH_LIM; k++)
			send_word(k[0] ? rmwq_pkg::OP_TRY : rmwq_pkg::OP_LOCK, 5'd9);
		send_word(rmwq_pkg::OP_LOCK, 5'd9);
		send_word(rmwq_pkg::OP_TRY, 5'd9);
		send_word(rmwq_pkg::OP_LOCK, 5'd3);
		for (int k = 0; k < DEPTH_LIM; k++)
			send_word(rmwq_pkg::OP_UNLOCK, 5'd9);
		drain_results();
	endtask

	task automatic random_traffic(input int n_words, input int span);
		rmwq_pkg::op_t             o;
		logic [rmwq_pkg::ID_W-1:0] id;
		logic [rmwq_pkg::ID_W-1:0] base;
		int                        r;
		int                        woken;
		base  = rmwq_pkg::ID_W'($urandom);
		woken = -1;
		for (int k = 0; k < n_words; k++) begin
			r  = $urandom_range(0, 99);
			id = base + rmwq_pkg::ID_W'($urandom_range(0, span - 1));
			o  = rmwq_pkg::OP_LOCK;
			if (r < 6) begin
				o  = rmwq_pkg::op_t'($urandom_range(0, 3));
				id = rmwq_pkg::ID_W'($urandom);
			end else if (woken >= 0 && r < 60) begin
				id = rmwq_pkg::ID_W'(woken);
			end else if (lk_held && r < 36) begin
				o  = rmwq_pkg::OP_UNLOCK;
				id = lk_owner;
			end else if (wait_q.size() > 0 && r < 46) begin
				o  = rmwq_pkg::OP_CANCEL;
				id = wait_q[$urandom_range(0, wait_q.size() - 1)];
			end else if (r < 76) begin
				o = rmwq_pkg::OP_LOCK;
			end else if (r < 86) begin
				o = rmwq_pkg::OP_TRY;
			end else if (lk_held && r < 94) begin
				o  = $urandom_range(0, 1) ? rmwq_pkg::OP_LOCK : rmwq_pkg::OP_TRY;
				id = lk_owner;
			end else begin
				o = rmwq_pkg::op_t'($urandom_range(0, 3));
			end
			send_word(o, id);
			woken = last_pred.wake_valid ? int'(last_pred.wake_id) : -1;
		end
		drain_results();
	endtask

	task automatic test_random();
		gap_pct = 15;
		random_traffic(120, 4);
		random_traffic(160, 24);
		gap_pct = 0;
		random_traffic(60, 8);
		gap_pct = 15;
		random_traffic(100, 32);
	endtask

	task automatic test_backpressure();
		gap_pct = 0;
		hold_cycles = 300;
		random_traffic(40, 6);
	endtask

	task automatic test_quiet_tail();
		quiet = 1'b1;
		random_traffic(150, 20);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_queue_limits();
		test_depth_saturation();
		test_random();
		test_backpressure();
		test_quiet_tail();
		repeat (LAT_CYCLES) @(posedge clk);
		if (err_count == 0 && result_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
